FILE: rtl/lp_distance_matrix_core_assert.svh
// Assertion macros for the distance matrix core
`ifndef LP_DISTANCE_MATRIX_CORE_ASSERT_SVH
`define LP_DISTANCE_MATRIX_CORE_ASSERT_SVH
// implication checked every clock, off in reset
`define LPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define LPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants and types for the Lp distance matrix core.
// ----------------------------------------------------------------------------
package lpd_pkg;
  localparam int MAX_VECTOR_LENGTH = 256;
  localparam int MAX_VECTORS       = 4096;
  localparam int ELEMENT_WIDTH     = 16;

  localparam logic [1:0] MODE_MAX  = 2'd0;
  localparam logic [1:0] MODE_L1   = 2'd1;
  localparam logic [1:0] MODE_L2   = 2'd2;
  localparam logic [1:0] MODE_L3   = 2'd3;

  localparam logic [1:0] REG_POWER_MODE   = 2'd0;
  localparam logic [1:0] REG_VECTOR_LEN   = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd2;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd3;

  // classified element headed for the back end
  typedef struct packed {
    logic [16:0] absdiff;
    logic        vec_last;
    logic [1:0]  mode;
  } lpd_elem_t;

  // finished vector pair waiting for the root unit
  typedef struct packed {
    logic [63:0] acc;
    logic [1:0]  mode;
    logic [11:0] row;
    logic [11:0] col;
    logic        done;
  } lpd_job_t;
endpackage

FILE: rtl/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// Takes element pairs, forms |a-b| and tags the last element of a vector.
// ----------------------------------------------------------------------------
module lpd_front import lpd_pkg::*; #(
  parameter int MAX_LEN = MAX_VECTOR_LENGTH,
  parameter int EW      = ELEMENT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] elem_a,
  input  logic [15:0] elem_b,
  input  logic [1:0]  mode,
  input  logic [8:0]  vector_len,
  output logic        q_valid,
  input  logic        q_ready,
  output lpd_elem_t   q_data
);
  logic [7:0]  elem_cnt_r;
  logic [8:0]  len;
  logic signed [16:0] sa, sb, d;
  logic        q_valid_r;
  lpd_elem_t   q_data_r;
  logic        take;

  always_comb begin
    if (vector_len == 9'd0) len = 9'd1;
    else if ({23'd0, vector_len} > MAX_LEN) len = 9'(MAX_LEN);
    else len = vector_len;
  end

  assign sa = 17'(signed'(elem_a[EW-1:0]));
  assign sb = 17'(signed'(elem_b[EW-1:0]));
  assign d  = sa - sb;

  assign in_ready = !q_valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r  <= 1'b0;
      elem_cnt_r <= '0;
    end else begin
      if (take) begin
        q_valid_r <= 1'b1;
        if ({1'b0, elem_cnt_r} + 9'd1 < len) elem_cnt_r <= elem_cnt_r + 8'd1;
        else elem_cnt_r <= '0;
      end else if (q_ready) begin
        q_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_data_r.absdiff  <= d[16] ? -d : d;
      q_data_r.vec_last <= !({1'b0, elem_cnt_r} + 9'd1 < len);
      q_data_r.mode     <= mode;
    end
  end

  assign q_valid = q_valid_r;
  assign q_data  = q_data_r;
endmodule

FILE: rtl/lpd_accum.sv
// ----------------------------------------------------------------------------
// lpd_accum
// Power stage and accumulator; hands finished vector pairs to the root unit.
// ----------------------------------------------------------------------------
module lpd_accum import lpd_pkg::*; #(
  parameter int MAX_VEC = MAX_VECTORS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       e_valid,
  output logic       e_ready,
  input  lpd_elem_t  e_data,
  input  logic [12:0] row_count,
  input  logic [12:0] column_count,
  output logic       j_valid,
  input  logic       j_ready,
  output lpd_job_t   j_data
);
  // stage 1: element
  logic        s1_v_r;
  lpd_elem_t   s1_r;
  // stage 2: square
  logic        s2_v_r;
  lpd_elem_t   s2_r;
  logic [33:0] sq_r;
  // stage 3: cube, accumulate
  logic        s3_v_r;
  lpd_elem_t   s3_r;
  logic [33:0] sq3_r;
  logic [50:0] pw_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [11:0] row_r, col_r;
  logic        j_valid_r, j_valid_nxt;
  lpd_job_t    j_r;
  logic [12:0] rows, cols;
  logic        last_row, last_col, adv, fin;

  // the pipe holds only when a finished result cannot leave
  assign adv     = !(j_valid_r && !j_ready);
  assign e_ready = adv;
  assign fin     = adv && s3_v_r && s3_r.vec_last;

  always_comb begin
    rows = (row_count == 13'd0) ? 13'd1 :
           ({19'd0, row_count} > MAX_VEC) ? 13'(MAX_VEC) : row_count;
    cols = (column_count == 13'd0) ? 13'd1 :
           ({19'd0, column_count} > MAX_VEC) ? 13'(MAX_VEC) : column_count;
    last_row = {1'b0, row_r} + 13'd1 >= rows;
    last_col = {1'b0, col_r} + 13'd1 >= cols;
    case (s3_r.mode)
      MODE_MAX: acc_nxt = ({47'd0, s3_r.absdiff} > acc_r) ? {47'd0, s3_r.absdiff} : acc_r;
      MODE_L1:  acc_nxt = acc_r + {47'd0, s3_r.absdiff};
      MODE_L2:  acc_nxt = acc_r + {30'd0, sq3_r};
      default:  acc_nxt = acc_r + {13'd0, pw_r};
    endcase
    j_valid_nxt = fin || (j_valid_r && !j_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; j_valid_r <= 1'b0;
      acc_r <= '0; row_r <= '0; col_r <= '0;
    end else begin
      j_valid_r <= j_valid_nxt;
      if (adv) begin
        s1_v_r <= e_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        if (s3_v_r) begin
          if (s3_r.vec_last) begin
            acc_r <= '0;
            if (!last_row) row_r <= row_r + 12'd1;
            else begin
              row_r <= '0;
              col_r <= last_col ? 12'd0 : col_r + 12'd1;
            end
          end else begin
            acc_r <= acc_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= e_data;
      s2_r  <= s1_r;
      sq_r  <= 34'(s1_r.absdiff) * 34'(s1_r.absdiff);
      s3_r  <= s2_r;
      sq3_r <= sq_r;
      pw_r  <= 51'(sq_r) * 51'(s2_r.absdiff);
      if (fin) begin
        j_r.acc  <= acc_nxt;
        j_r.mode <= s3_r.mode;
        j_r.row  <= row_r;
        j_r.col  <= col_r;
        j_r.done <= last_row && last_col;
      end
    end
  end

  assign j_valid = j_valid_r;
  assign j_data  = j_r;
endmodule

FILE: rtl/lpd_root.sv
// ----------------------------------------------------------------------------
// lpd_root
// Bit-serial floor square / cube root; per bit, ST_SQ then ST_MUL.
// ----------------------------------------------------------------------------
module lpd_root import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        j_valid,
  output logic        j_ready,
  input  lpd_job_t    j_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  st_r;
  lpd_job_t    job_r;
  logic [23:0] root_r, cand;
  logic [4:0]  bit_r;
  logic [47:0] sq_r;
  logic [62:0] cube;
  logic [63:0] pw;

  // cube roots stay below 2^21, so the square fits 42 bits
  assign cand = root_r | (24'd1 << bit_r);
  assign cube = sq_r[41:0] * cand[20:0];
  assign pw   = (job_r.mode == MODE_L3) ? {1'b0, cube} : {16'd0, sq_r};
  assign j_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: if (j_valid) begin
          job_r  <= j_data;
          root_r <= '0;
          bit_r  <= (j_data.mode == MODE_L3) ? 5'd20 : 5'd23;
          st_r   <= (j_data.mode == MODE_L2 || j_data.mode == MODE_L3) ? ST_SQ : ST_OUT;
        end
        ST_SQ: begin
          sq_r <= cand * cand;
          st_r <= ST_MUL;
        end
        ST_MUL: begin
          if (pw <= job_r.acc) root_r <= cand;
          if (bit_r == 5'd0) st_r <= ST_OUT;
          else begin
            bit_r <= bit_r - 5'd1;
            st_r  <= ST_SQ;
          end
        end
        ST_OUT: if (out_tready) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {job_r.col, job_r.row,
                       (job_r.mode == MODE_L2 || job_r.mode == MODE_L3) ?
                       root_r : job_r.acc[23:0]};
  assign out_tlast  = job_r.done;
endmodule

FILE: rtl/lp_distance_matrix_core.sv
// ----------------------------------------------------------------------------
// lp_distance_matrix_core
// Streaming pairwise Lp / Chebyshev distance matrix engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one item per element pair, tdata = {elem_b, elem_a}.
//   Items for a vector pair run back to back; rows step first, then columns.
//   out_ channel: one item per vector pair with distance and indices;
//   out_tlast marks the final entry of the matrix.
//   cfg_ APB port: registers at 0x0 power_mode, 0x4 vector_len,
//   0x8 row_count, 0xC column_count. Write only while idle.
// Throughput: one element per cycle through the front end and the three-stage
//   power pipe while no stall holds them. The output unit takes one result at a
//   time, only from idle; modes 2 and 3 run a bit-serial root, a square step
//   and a multiply-compare step per result bit. Path: front queue register,
//   power stages s1 to s3, job register, root unit.
// Reset: synchronous, all counters and the accumulator cleared, registers
//   back to defaults (mode 2, all lengths 1).
// Stall: a held out_tready backs up the root unit, then the accumulator,
//   then the front queue register, then in_tready drops.
// ----------------------------------------------------------------------------
module lp_distance_matrix_core import lpd_pkg::*; #(
  parameter int MAX_LEN = MAX_VECTOR_LENGTH,
  parameter int MAX_VEC = MAX_VECTORS,
  parameter int EW      = ELEMENT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] elem_a, [31:16] elem_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [23:0] distance, [35:24] row_index,
                                  // [47:36] column_index
  output logic        out_tlast,  // matrix_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [1:0]  mode_r;
  logic [8:0]  vlen_r;
  logic [12:0] rows_r, cols_r;
  logic        e_valid, e_ready, j_valid, j_ready;
  lpd_elem_t   e_data;
  lpd_job_t    j_data;
  logic [1:0]  reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_L2; vlen_r <= 9'd1; rows_r <= 13'd1; cols_r <= 13'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        REG_POWER_MODE:   mode_r <= cfg_pwdata[1:0];
        REG_VECTOR_LEN:   vlen_r <= cfg_pwdata[8:0];
        REG_ROW_COUNT:    rows_r <= cfg_pwdata[12:0];
        REG_COLUMN_COUNT: cols_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POWER_MODE:   cfg_prdata = {30'd0, mode_r};
      REG_VECTOR_LEN:   cfg_prdata = {23'd0, vlen_r};
      REG_ROW_COUNT:    cfg_prdata = {19'd0, rows_r};
      default:          cfg_prdata = {19'd0, cols_r};
    endcase
  end

  lpd_front #(.MAX_LEN(MAX_LEN), .EW(EW)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .elem_a(in_tdata[15:0]), .elem_b(in_tdata[31:16]), .mode(mode_r),
    .vector_len(vlen_r), .q_valid(e_valid), .q_ready(e_ready), .q_data(e_data)
  );

  lpd_accum #(.MAX_VEC(MAX_VEC)) u_accum (
    .clk, .rst_n, .e_valid, .e_ready, .e_data, .row_count(rows_r),
    .column_count(cols_r), .j_valid, .j_ready, .j_data
  );

  lpd_root u_root (
    .clk, .rst_n, .j_valid, .j_ready, .j_data,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  `include "lp_distance_matrix_core_assert.svh"
  `LPD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `LPD_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  `LPD_ASSERT_IMP(a_stall_in, j_valid && !j_ready, !e_ready)
endmodule

FILE: tb/sv/lpd_scoreboard.sv
// ----------------------------------------------------------------------------
// lpd_scoreboard
// Watches the cfg_, in_ and out_ ports of the distance matrix core. Each
// register write and each accepted element pair updates a local model of the
// core, and each expected distance entry is checked against the out_ items.
// ----------------------------------------------------------------------------
module lpd_scoreboard import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] distance;
    logic [11:0] row;
    logic [11:0] col;
    logic        done;
  } dist_entry_t;

  dist_entry_t entry_q[$];

  logic [1:0]        mode_r;
  logic [8:0]        vlen_r;
  logic [12:0]       rows_r;
  logic [12:0]       cols_r;
  longint unsigned   acc;
  int unsigned       elem_cnt;
  int unsigned       row_cnt;
  int unsigned       col_cnt;

  function automatic int unsigned bounded(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  // floor square or cube root, one bit per pass from the top
  function automatic longint unsigned floor_root(longint unsigned s, logic [1:0] p);
    longint unsigned r;
    longint unsigned c;
    longint unsigned pw;
    int              top_bit;
    r = 0;
    top_bit = (p == MODE_L2) ? 23 : 20;
    for (int k = top_bit; k >= 0; k--) begin
      c = r | (64'd1 << k);
      pw = (p == MODE_L2) ? c * c : c * c * c;
      if (pw <= s) r = c;
    end
    return r;
  endfunction

  task automatic take_pair(input logic [31:0] data);
    int              a;
    int              b;
    longint unsigned ad;
    longint unsigned dist_val;
    bit              last_row;
    bit              last_col;
    dist_entry_t     e;
    a = int'(signed'(data[15:0]));
    b = int'(signed'(data[31:16]));
    ad = (a > b) ? longint'(a - b) : longint'(b - a);
    case (mode_r)
      MODE_MAX: if (ad > acc) acc = ad;
      MODE_L1:  acc += ad;
      MODE_L2:  acc += ad * ad;
      default:  acc += ad * ad * ad;
    endcase
    if (elem_cnt + 1 < bounded(vlen_r, MAX_VECTOR_LENGTH)) begin
      elem_cnt = (elem_cnt + 1) & 8'hFF;
      return;
    end
    elem_cnt = 0;
    dist_val = (mode_r >= MODE_L2) ? floor_root(acc, mode_r) : acc;
    acc = 0;
    last_row = (row_cnt + 1 >= bounded(rows_r, MAX_VECTORS));
    last_col = (col_cnt + 1 >= bounded(cols_r, MAX_VECTORS));
    e.distance = dist_val[23:0];
    e.row = row_cnt[11:0];
    e.col = col_cnt[11:0];
    e.done = last_row && last_col;
    entry_q.push_back(e);
    if (!last_row) row_cnt = (row_cnt + 1) & 12'hFFF;
    else begin
      row_cnt = 0;
      col_cnt = last_col ? 0 : ((col_cnt + 1) & 12'hFFF);
    end
  endtask

  task automatic check_entry(input logic [47:0] data, input logic last);
    dist_entry_t e;
    if (entry_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result item %h last %b", data, last);
      return;
    end
    e = entry_q.pop_front();
    if (data[23:0] !== e.distance || data[35:24] !== e.row || data[47:36] !== e.col ||
        last !== e.done) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: exp dist %0d row %0d col %0d done %0d, got dist %0d row %0d col %0d done %0d",
                 e.distance, e.row, e.col, e.done, data[23:0], data[35:24], data[47:36],
                 last);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_r = MODE_L2;
      vlen_r = 9'd1;
      rows_r = 13'd1;
      cols_r = 13'd1;
      acc = 0;
      elem_cnt = 0;
      row_cnt = 0;
      col_cnt = 0;
      entry_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_POWER_MODE:   mode_r = cfg_pwdata[1:0];
          REG_VECTOR_LEN:   vlen_r = cfg_pwdata[8:0];
          REG_ROW_COUNT:    rows_r = cfg_pwdata[12:0];
          REG_COLUMN_COUNT: cols_r = cfg_pwdata[12:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_pair(in_tdata);
      if (out_tvalid && out_tready) check_entry(out_tdata, out_tlast);
    end
    pending = entry_q.size();
  end
endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for lp_distance_matrix_core: directed extremes and special
// settings, then random phases of vector pairs under random idling on both
// sides, with one long output stall; the scoreboard does all checking.
// ----------------------------------------------------------------------------
module tb;
  import lpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int TARGET_ITEMS = 1250;

  // element patterns
  localparam int PAT_RANDOM  = 0;
  localparam int PAT_EXTREME = 1;
  localparam int PAT_SMALL   = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [15:0] elem_a, [31:16] elem_b
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [23:0] distance, [35:24] row, [47:36] column
  logic        out_tlast;         // matrix_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_out = 1'b0;   // asks the receiver for one long stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lp_distance_matrix_core i_dut (.*);

  lpd_scoreboard i_scoreboard (.*);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lp_distance_matrix_core regression: fail");
      $finish;
    end
  end

  // receiver: random ready delay per result, one long hold on request
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // let every expected entry come out, then let the pipe settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_elem(input int pat);
    case (pat)
      PAT_EXTREME: case ($urandom_range(0, 3))
                     0: return 16'h8000;
                     1: return 16'h7FFF;
                     2: return 16'h0000;
                     default: return 16'hFFFF;
                   endcase
      PAT_SMALL:   return 16'($signed($urandom_range(0, 16)) - 8);
      default:     return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [31:0] data);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 16);
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // one setting of all four registers and a run of whole vector pairs
  task automatic run_phase(input logic [1:0] mode, input int len, input int rows,
                           input int cols, input int pairs, input int pat);
    int eff_len;
    eff_len = (len == 0) ? 1 : ((len > MAX_VECTOR_LENGTH) ? MAX_VECTOR_LENGTH : len);
    drain();
    reg_write(REG_POWER_MODE, 32'(mode));
    reg_write(REG_VECTOR_LEN, 32'(len));
    reg_write(REG_ROW_COUNT, 32'(rows));
    reg_write(REG_COLUMN_COUNT, 32'(cols));
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < pairs; p++)
      for (int e = 0; e < eff_len; e++)
        send_item({pick_elem(pat), pick_elem(pat)});
    in_tvalid <= 1'b0;
  endtask

  initial begin
    logic [1:0] m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: L2, single-element vectors, 1x1 matrix
    no_gaps = 1'b0;
    for (int i = 0; i < 3; i++) send_item({pick_elem(PAT_EXTREME), pick_elem(PAT_EXTREME)});
    in_tvalid <= 1'b0;

    // Chebyshev, matrix wraps after 3x2
    run_phase(MODE_MAX, 1, 3, 2, 8, PAT_EXTREME);
    // zero length and counts behave as one
    run_phase(MODE_L1, 0, 0, 0, 3, PAT_EXTREME);
    run_phase(MODE_L1, 4, 2, 2, 3, PAT_EXTREME);
    // oversize counts clamp
    run_phase(MODE_L2, 2, 5000, 8191, 3, PAT_EXTREME);
    // longest vector, largest cube sum
    run_phase(MODE_L3, 300, 2, 1, 1, PAT_EXTREME);

    // long output stall while the sender keeps going
    drain();
    hold_out = 1'b1;
    run_phase(MODE_L1, 2, 5, 3, 40, PAT_RANDOM);

    // random phases, mostly short vectors, the sender pauses between them
    while (items_sent < TARGET_ITEMS) begin
      m = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
        run_phase(m, $urandom_range(0, 64), $urandom_range(0, 6), $urandom_range(0, 6),
                  $urandom_range(1, 4), $urandom_range(0, 2));
      else
        run_phase(m, $urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(1, 4),
                  $urandom_range(5, 30), $urandom_range(0, 2));
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("lp_distance_matrix_core regression: pass");
    end else begin
      $display("lp_distance_matrix_core regression: fail");
    end
    $finish;
  end
endmodule
